FILE: rtl/core/eodh_pkg.sv
// Shared constants, register codes and controller/datapath command types.
`default_nettype none
package eodh_pkg;

  localparam int RES_X_DEF       = 512;
  localparam int RES_Y_DEF       = 512;
  localparam int MAX_ITER_DEF    = 4096;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 13;
  localparam int BIN_W      = 9;
  localparam int CH_W       = 2;
  localparam int MASK_W     = 3;
  localparam int NUM_CH     = 3;

  // pixel mapping: x = floor(M / DIV_X), M = floor((BX + my*KX) / 2^30)
  localparam int DIV_X  = 77;
  localparam int DIV_Y  = 17325;
  localparam int MUL_X  = 100;
  localparam int MUL_Y  = 22500;
  localparam int OFF_X  = 77;
  localparam int OFF_Y  = 498883;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_RE       = 3'd0,
    CFG_START_IM       = 3'd1,
    CFG_REAL_MIX_ORBIT = 3'd2,
    CFG_REAL_MIX_CONST = 3'd3,
    CFG_IMAG_MIX_ORBIT = 3'd4,
    CFG_IMAG_MIX_CONST = 3'd5,
    CFG_BAND0_LIMIT    = 3'd6,
    CFG_BAND1_LIMIT    = 3'd7
  } cfg_idx_t;

  localparam logic REQ_TRAJ = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic clr;
    logic accept;
    logic mul;
    logic sq1;
    logic sq2;
    logic pl1;
    logic pl2;
    logic pl3;
    logic div;
    logic pwr;
    logic esc;
    logic horb;
    logic hden;
    logic hwr;
    logic rda;
    logic rdw;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_read;
    logic ovf1;
    logic ovf2;
    logic mag_esc;
    logic k_last;
    logic p_done;
    logic orb_valid;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/eodh_in_if.sv
// Request channel interface.
`default_nettype none
interface eodh_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [31:0]                c_re;
  logic signed [31:0]                c_im;
  logic [eodh_pkg::BIN_W-1:0]        bin_x;
  logic [eodh_pkg::BIN_W-1:0]        bin_y;
  logic [eodh_pkg::CH_W-1:0]         bin_channel;

  modport source(output valid, req_type, c_re, c_im, bin_x, bin_y, bin_channel,
                 input ready);
  modport sink(input valid, req_type, c_re, c_im, bin_x, bin_y, bin_channel,
               output ready);
endinterface
`default_nettype wire

FILE: rtl/core/eodh_out_if.sv
// Response channel interface.
`default_nettype none
interface eodh_out_if;
  logic                         valid;
  logic                         ready;
  logic                         resp_kind;
  logic [eodh_pkg::STEP_W-1:0]  escape_step;
  logic                         did_escape;
  logic [eodh_pkg::MASK_W-1:0]  channel_mask;
  logic [31:0]                  bin_count;

  modport source(output valid, resp_kind, escape_step, did_escape, channel_mask,
                 bin_count, input ready);
  modport sink(input valid, resp_kind, escape_step, did_escape, channel_mask,
               bin_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/eodh_ctrl.sv
// Sequencing state machine for trajectory, histogram update and bin read.
`default_nettype none
module eodh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire eodh_pkg::sts_t sts,
  output eodh_pkg::cmd_t     cmd
);

  typedef enum logic [19:0] {
    S_CLEAR = 20'h00001,
    S_IDLE  = 20'h00002,
    S_MUL1  = 20'h00004,
    S_SQ1   = 20'h00008,
    S_MUL2  = 20'h00010,
    S_SQ2   = 20'h00020,
    S_MUL3  = 20'h00040,
    S_MAG   = 20'h00080,
    S_PL1   = 20'h00100,
    S_PL2   = 20'h00200,
    S_PL3   = 20'h00400,
    S_DIV   = 20'h00800,
    S_PWR   = 20'h01000,
    S_ESC   = 20'h02000,
    S_HORB  = 20'h04000,
    S_HDEN  = 20'h08000,
    S_HWR   = 20'h10000,
    S_RDA   = 20'h20000,
    S_RDW   = 20'h40000,
    S_FIN   = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.req_read ? S_RDA : S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.sq1   = 1'b1;
        state_nxt = sts.ovf1 ? S_ESC : S_MUL2;
      end
      S_MUL2: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq2   = 1'b1;
        state_nxt = sts.ovf2 ? S_ESC : S_MUL3;
      end
      S_MUL3: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        state_nxt = sts.mag_esc ? S_ESC : S_PL1;
      end
      S_PL1: begin
        cmd.pl1   = 1'b1;
        state_nxt = S_PL2;
      end
      S_PL2: begin
        cmd.pl2   = 1'b1;
        state_nxt = S_PL3;
      end
      S_PL3: begin
        cmd.pl3   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.pwr   = 1'b1;
        state_nxt = sts.k_last ? S_FIN : S_MUL1;
      end
      S_ESC: begin
        cmd.esc   = 1'b1;
        state_nxt = S_HORB;
      end
      S_HORB: begin
        if (sts.p_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.horb  = 1'b1;
          state_nxt = S_HDEN;
        end
      end
      S_HDEN: begin
        cmd.hden  = 1'b1;
        state_nxt = sts.orb_valid ? S_HWR : S_HORB;
      end
      S_HWR: begin
        cmd.hwr   = 1'b1;
        state_nxt = S_HORB;
      end
      S_RDA: begin
        cmd.rda   = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        cmd.rdw   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/eodh_dp.sv
// Datapath: iteration arithmetic, pixel mapping, memories, result register.
`default_nettype none
module eodh_dp #(
  parameter int RES_X       = eodh_pkg::RES_X_DEF,
  parameter int RES_Y       = eodh_pkg::RES_Y_DEF,
  parameter int MAX_ITER    = eodh_pkg::MAX_ITER_DEF,
  parameter int COUNT_WIDTH = eodh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [eodh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [eodh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_req_type,
  input  wire logic signed [31:0]                in_c_re,
  input  wire logic signed [31:0]                in_c_im,
  input  wire logic [eodh_pkg::BIN_W-1:0]        in_bin_x,
  input  wire logic [eodh_pkg::BIN_W-1:0]        in_bin_y,
  input  wire logic [eodh_pkg::CH_W-1:0]         in_bin_channel,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_resp_kind,
  output logic [eodh_pkg::STEP_W-1:0]            out_escape_step,
  output logic                                   out_did_escape,
  output logic [eodh_pkg::MASK_W-1:0]            out_channel_mask,
  output logic [31:0]                            out_bin_count,
  input  wire eodh_pkg::cmd_t                    cmd,
  output eodh_pkg::sts_t                         sts
);

  localparam int NPIX = RES_X * RES_Y;
  localparam int PIXW = $clog2(NPIX);
  localparam int KW   = $clog2(MAX_ITER + 1);
  localparam int OAW  = $clog2(MAX_ITER);
  localparam int CW   = COUNT_WIDTH;
  localparam int RW   = eodh_pkg::NUM_CH * CW;
  localparam int QW   = $clog2((RES_X > RES_Y) ? RES_X : RES_Y);
  localparam int DW   = $clog2(eodh_pkg::DIV_Y * (2 ** QW)) + 1;

  localparam logic signed [63:0] KX = 64'(RES_Y) * 64'(eodh_pkg::MUL_X);
  localparam logic signed [63:0] KY = 64'(RES_Y) * 64'(eodh_pkg::MUL_Y);
  localparam logic signed [63:0] BX = 64'(RES_X) * 64'(eodh_pkg::OFF_X) * (64'd1 << 29);
  localparam logic signed [63:0] BY = 64'(RES_Y) * 64'(eodh_pkg::OFF_Y) * (64'd1 << 24);
  localparam logic signed [63:0] LX = 64'(RES_X) * 64'(eodh_pkg::DIV_X);
  localparam logic signed [63:0] LY = 64'(RES_Y) * 64'(eodh_pkg::DIV_Y);

  // reciprocals: exact floor division for every on-grid numerator (n < L, 2^S >= L*div)
  localparam int SX = $clog2(LX * 64'(eodh_pkg::DIV_X));
  localparam int SY = $clog2(LY * 64'(eodh_pkg::DIV_Y));
  localparam logic [63:0] RX =
    ((64'd1 << SX) + 64'(eodh_pkg::DIV_X) - 64'd1) / 64'(eodh_pkg::DIV_X);
  localparam logic [63:0] RY =
    ((64'd1 << SY) + 64'(eodh_pkg::DIV_Y) - 64'd1) / 64'(eodh_pkg::DIV_Y);
  localparam int RXW = $clog2(RX + 64'd1);
  localparam int RYW = $clog2(RY + 64'd1);
  localparam int PXW = DW + RXW;
  localparam int PYW = DW + RYW;

  // configuration
  logic signed [31:0] start_re_r, start_im_r;
  logic signed [15:0] rmo_r, rmc_r, imo_r, imc_r;
  logic [eodh_pkg::STEP_W-1:0] band0_r, band1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_re_r <= '0;
      start_im_r <= '0;
      rmo_r      <= 16'sd16384;
      rmc_r      <= '0;
      imo_r      <= 16'sd16384;
      imc_r      <= '0;
      band0_r    <= 13'd150;
      band1_r    <= 13'd1200;
    end else if (cfg_we) begin
      unique case (eodh_pkg::cfg_idx_t'(cfg_index))
        eodh_pkg::CFG_START_RE:       start_re_r <= cfg_data;
        eodh_pkg::CFG_START_IM:       start_im_r <= cfg_data;
        eodh_pkg::CFG_REAL_MIX_ORBIT: rmo_r      <= cfg_data[15:0];
        eodh_pkg::CFG_REAL_MIX_CONST: rmc_r      <= cfg_data[15:0];
        eodh_pkg::CFG_IMAG_MIX_ORBIT: imo_r      <= cfg_data[15:0];
        eodh_pkg::CFG_IMAG_MIX_CONST: imc_r      <= cfg_data[15:0];
        eodh_pkg::CFG_BAND0_LIMIT:    band0_r    <= cfg_data[eodh_pkg::STEP_W-1:0];
        eodh_pkg::CFG_BAND1_LIMIT:    band1_r    <= cfg_data[eodh_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // orbit arithmetic
  logic signed [31:0] x_r, y_r, cr_r, ci_r;
  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [64:0] dsq, a_w;
  logic signed [63:0] b_w;
  logic signed [32:0] nr, ni;
  logic               fit_a, fit_b, fit_nr, fit_ni;
  logic [64:0]        mag;

  always_comb begin
    dsq    = 65'(p0_r) - 65'(p1_r);
    a_w    = dsq >>> 28;
    b_w    = p2_r >>> 27;
    fit_a  = (a_w[64:31] == '0) || (a_w[64:31] == '1);
    fit_b  = (b_w[63:31] == '0) || (b_w[63:31] == '1);
    nr     = 33'(signed'(a_w[31:0])) + 33'(cr_r);
    ni     = 33'(signed'(b_w[31:0])) + 33'(ci_r);
    fit_nr = (nr[32] == nr[31]);
    fit_ni = (ni[32] == ni[31]);
    mag    = 65'($unsigned(p0_r)) + 65'($unsigned(p1_r));
  end

  // pixel mapping
  logic signed [47:0] mr0_r, mr1_r, mi0_r, mi1_r;
  logic signed [48:0] sum_x, sum_y;
  logic signed [34:0] mx, my;
  logic signed [63:0] tx_r, ty_r;
  logic signed [63:0] mqx, mqy;
  logic               off_r;
  logic [DW-1:0]      remx_r, remy_r;
  logic [PXW-1:0]     prod_x;
  logic [PYW-1:0]     prod_y;
  logic [QW-1:0]      qx_r, qy_r;
  logic [31:0]        pix_full;

  always_comb begin
    sum_x    = 49'(mr0_r) + 49'(mr1_r);
    sum_y    = 49'(mi0_r) + 49'(mi1_r);
    mx       = sum_x[48:14];
    my       = sum_y[48:14];
    mqx      = (BX + tx_r) >>> 30;
    mqy      = (BY - ty_r) >>> 30;
    prod_x   = PXW'(remx_r) * PXW'(RX);
    prod_y   = PYW'(remy_r) * PYW'(RY);
    pix_full = 32'(qy_r) * 32'(RES_X) + 32'(qx_r);
  end

  // step counter, histogram walk
  localparam int MASK_W_L = eodh_pkg::MASK_W;
  logic [KW-1:0]       k_r, p_r;
  logic [MASK_W_L-1:0] mask_r;
  logic                esc_r, kind_r;
  logic [31:0]         count_r;

  logic [PIXW:0]   orbit_mem [MAX_ITER];
  logic [PIXW:0]   orb_q;
  logic [RW-1:0]   den_mem [NPIX];
  logic [RW-1:0]   den_q, inc_row;
  logic [PIXW-1:0] h_addr_r, bin_addr_r, clr_cnt_r;
  logic [eodh_pkg::CH_W-1:0] bin_ch_r;
  logic            bin_bad_r;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   sel_cnt;
  logic [63:0]     sel64;

  always_comb begin
    inc_row = den_q;
    for (int c = 0; c < eodh_pkg::NUM_CH; c++) begin
      cnt = den_q[c*CW +: CW];
      if (mask_r[c] && (cnt != '1)) inc_row[c*CW +: CW] = cnt + 1'b1;
    end
    unique case (bin_ch_r)
      2'd0:    sel_cnt = den_q[0 +: CW];
      2'd1:    sel_cnt = den_q[CW +: CW];
      2'd2:    sel_cnt = den_q[2*CW +: CW];
      default: sel_cnt = '0;
    endcase
    sel64 = 64'(sel_cnt);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cr_r      <= in_c_re;
      ci_r      <= in_c_im;
      x_r       <= start_re_r;
      y_r       <= start_im_r;
      k_r       <= '0;
      kind_r    <= in_req_type;
      esc_r     <= 1'b0;
      mask_r    <= '0;
      count_r   <= '0;
      bin_addr_r <= PIXW'(32'(in_bin_y) * 32'(RES_X) + 32'(in_bin_x));
      bin_ch_r  <= in_bin_channel;
      bin_bad_r <= (32'(in_bin_x) >= 32'(RES_X)) || (32'(in_bin_y) >= 32'(RES_Y))
                   || (in_bin_channel > 2'd2);
    end
    if (cmd.mul) begin
      p0_r <= x_r * x_r;
      p1_r <= y_r * y_r;
      p2_r <= x_r * y_r;
    end
    if (cmd.sq1) begin
      x_r <= a_w[31:0];
      y_r <= b_w[31:0];
    end
    if (cmd.sq2) begin
      x_r <= nr[31:0];
      y_r <= ni[31:0];
    end
    if (cmd.pl1) begin
      mr0_r <= rmo_r * x_r;
      mr1_r <= rmc_r * cr_r;
      mi0_r <= imo_r * y_r;
      mi1_r <= imc_r * ci_r;
    end
    if (cmd.pl2) begin
      tx_r <= 64'(my) * KX;
      ty_r <= 64'(mx) * KY;
    end
    if (cmd.pl3) begin
      off_r   <= (mqx < 0) || (mqx >= LX) || (mqy < 0) || (mqy >= LY);
      remx_r  <= mqx[DW-1:0];
      remy_r  <= mqy[DW-1:0];
    end
    // quotient by reciprocal multiply, only meaningful when on grid
    if (cmd.div) begin
      qx_r <= prod_x[SX +: QW];
      qy_r <= prod_y[SY +: QW];
    end
    if (cmd.pwr) begin
      orbit_mem[k_r[OAW-1:0]] <= {pix_full[PIXW-1:0], ~off_r};
      k_r <= k_r + 1'b1;
    end
    if (cmd.esc) begin
      esc_r  <= 1'b1;
      mask_r <= {1'b1, 32'(k_r) < 32'(band1_r), 32'(k_r) < 32'(band0_r)};
      p_r    <= '0;
    end
    if (cmd.horb) orb_q <= orbit_mem[p_r[OAW-1:0]];
    if (cmd.hden) begin
      h_addr_r <= orb_q[PIXW:1];
      if (!orb_q[0]) p_r <= p_r + 1'b1;
    end
    if (cmd.hwr) p_r <= p_r + 1'b1;
    if (cmd.rdw) begin
      count_r <= (bin_bad_r) ? 32'd0
               : (sel64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sel64[31:0];
    end
  end

  // density memory: one row holds the three channel counts of a pixel
  always_ff @(posedge clk) begin
    if (cmd.clr) den_mem[clr_cnt_r] <= '0;
    else if (cmd.hwr) den_mem[h_addr_r] <= inc_row;
    if (cmd.hden) den_q <= den_mem[orb_q[PIXW:1]];
    else if (cmd.rda) den_q <= den_mem[bin_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // result register
  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_resp_kind    <= kind_r;
      out_escape_step  <= eodh_pkg::STEP_W'(k_r);
      out_did_escape   <= esc_r;
      out_channel_mask <= mask_r;
      out_bin_count    <= count_r;
    end
  end

  always_comb begin
    sts.clr_last  = (clr_cnt_r == PIXW'(NPIX - 1));
    sts.req_read  = (in_req_type == eodh_pkg::REQ_READ);
    sts.ovf1      = !fit_a || !fit_b;
    sts.ovf2      = !fit_a || !fit_b || !fit_nr || !fit_ni;
    sts.mag_esc   = (mag[64:60] != '0);
    sts.k_last    = (k_r == KW'(MAX_ITER - 1));
    sts.p_done    = (p_r == k_r);
    sts.orb_valid = orb_q[0];
    sts.out_busy  = out_valid_r && !out_ready;
  end

endmodule
`default_nettype wire

FILE: rtl/core/escape_orbit_density_histogram_top.sv
// Top level of the power-4 escape-orbit density histogram.
//
// Two request kinds share the in_ch stream. A trajectory request iterates
// z = z^4 + C from the configured start point in Q3.28; each step makes
// three passes through a shared 32x32 multiplier bank and a magnitude
// check, one pass through the mixing multipliers, a constant multiply, an
// offset and range stage, one reciprocal multiply per axis that turns the
// scaled point into a pixel, and the buffer write. On escape at step k the
// buffered pixels are walked with a read-modify-write of the density memory
// for each on-grid point (an off-grid point is read but not written),
// followed by a wrap-up that loads the response. A bin read reads the
// addressed density row and selects the channel count. One request is in
// flight at a time; the response register lets the next request be taken
// while a response waits. After reset the density memory is swept to zero,
// one pixel row a cycle, with in_ch.ready low; cfg writes are taken any time.
`default_nettype none
module escape_orbit_density_histogram_top #(
  parameter int RES_X       = eodh_pkg::RES_X_DEF,
  parameter int RES_Y       = eodh_pkg::RES_Y_DEF,
  parameter int MAX_ITER    = eodh_pkg::MAX_ITER_DEF,
  parameter int COUNT_WIDTH = eodh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  eodh_in_if.sink                               in_ch,
  eodh_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [eodh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [eodh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  eodh_pkg::cmd_t cmd;
  eodh_pkg::sts_t sts;

  // controller: owns in_ch.ready, a transfer happens only in its idle state
  eodh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: arithmetic, orbit buffer, density memory, response register
  eodh_dp #(
    .RES_X       (RES_X),
    .RES_Y       (RES_Y),
    .MAX_ITER    (MAX_ITER),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_ch.req_type),
    .in_c_re          (in_ch.c_re),
    .in_c_im          (in_ch.c_im),
    .in_bin_x         (in_ch.bin_x),
    .in_bin_y         (in_ch.bin_y),
    .in_bin_channel   (in_ch.bin_channel),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_resp_kind    (out_ch.resp_kind),
    .out_escape_step  (out_ch.escape_step),
    .out_did_escape   (out_ch.did_escape),
    .out_channel_mask (out_ch.channel_mask),
    .out_bin_count    (out_ch.bin_count),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
`default_nettype wire

FILE: rtl/core/eodh_checker.sv
// Port-level checker for the histogram top, with its bind.
`default_nettype none
module eodh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        resp_kind,
  input wire logic [12:0] escape_step,
  input wire logic        did_escape,
  input wire logic [2:0]  channel_mask,
  input wire logic [31:0] bin_count
);

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("ready during clear sweep");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && resp_kind) |-> (escape_step == 13'd0 && !did_escape
                                  && channel_mask == 3'd0))
    else $error("read response carries trajectory fields");

  a_traj_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !resp_kind) |-> (channel_mask[2] == did_escape && bin_count == 32'd0))
    else $error("trajectory response inconsistent");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("response dropped");

endmodule

bind escape_orbit_density_histogram_top eodh_checker u_eodh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .resp_kind    (out_ch.resp_kind),
  .escape_step  (out_ch.escape_step),
  .did_escape   (out_ch.did_escape),
  .channel_mask (out_ch.channel_mask),
  .bin_count    (out_ch.bin_count)
);
`default_nettype wire
